>>> hw/rtl/seeded_hash_coefficient_sampler_macros.svh
// Assertion macros for the seeded hash coefficient sampler
`ifndef SEEDED_HASH_COEFFICIENT_SAMPLER_MACROS_SVH
`define SEEDED_HASH_COEFFICIENT_SAMPLER_MACROS_SVH
`ifndef ASSERT_OFF
`define SHCS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define SHCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SHCS_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define SHCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/shcs_pkg.sv
// Shared types and constants for the seeded hash coefficient sampler
`timescale 1ns / 1ps
package shcs_pkg;

    localparam int Q_W     = 31;
    localparam int RANK_W  = 4;
    localparam int DEG_W   = 11;
    localparam int ETA_W   = 5;
    localparam int HASH_W  = 32;
    localparam int ROT_L   = 5;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [HASH_W-1:0] HASH_INIT = 32'h9e37_79b9;

    localparam logic [1:0] FUNC_LOAD     = 2'd0;
    localparam logic [1:0] FUNC_UNIFORM  = 2'd1;
    localparam logic [1:0] FUNC_BINOMIAL = 2'd2;

    localparam logic [1:0] REG_MODULUS = 2'd0;
    localparam logic [1:0] REG_RANK    = 2'd1;
    localparam logic [1:0] REG_DEGREE  = 2'd2;
    localparam logic [1:0] REG_ETA     = 2'd3;

    localparam logic [Q_W-1:0]    MODULUS_RST = 31'd3329;
    localparam logic [RANK_W-1:0] RANK_RST    = 4'd2;
    localparam logic [DEG_W-1:0]  DEGREE_RST  = 11'd256;
    localparam logic [ETA_W-1:0]  ETA_RST     = 5'd2;

    typedef struct packed {
        logic [Q_W-1:0]    modulus_q;
        logic [RANK_W-1:0] rank_k;
        logic [DEG_W-1:0]  degree_n;
        logic [ETA_W-1:0]  eta_bits;
    } cfg_t;

    function automatic logic [HASH_W-1:0] hash_round(
        input logic [HASH_W-1:0] h,
        input logic [7:0]        b,
        input logic [HASH_W-1:0] ctr
    );
        logic [HASH_W-1:0] x;
        logic [HASH_W-1:0] r;
        x = h ^ {24'd0, b};
        r = {x[HASH_W-ROT_L-1:0], x[HASH_W-1:HASH_W-ROT_L]};
        return r + ctr;
    endfunction

endpackage

>>> hw/rtl/shcs_seed_mem.sv
// Seed byte memory: one write port, one registered read port
`timescale 1ns / 1ps
module shcs_seed_mem #(
    parameter int SEED_BYTES = 32,
    parameter int IDX_W      = 5
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  logic [7:0]       wdata,
    input  logic             re,
    input  logic [IDX_W-1:0] raddr,
    output logic [7:0]       rdata
);
    logic [7:0] mem [SEED_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> hw/rtl/shcs_rem_unit.sv
// Bit-serial restoring remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps
module shcs_rem_unit (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [31:0]             dividend,
    input  logic [shcs_pkg::Q_W-1:0] divisor,
    output logic                    done,
    output logic [shcs_pkg::Q_W-1:0] remainder
);
    import shcs_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [31:0]       dvd_reg, dvd_next;
    logic [31:0]       rem_reg, rem_next;
    logic [31:0]       shifted;
    logic [32:0]       diff;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        shifted   = {rem_reg[30:0], dvd_reg[31]};
        diff      = {1'b0, shifted} - {2'b00, divisor};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next = diff[32] ? shifted : diff[31:0];
            dvd_next = {dvd_reg[30:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg[Q_W-1:0];
endmodule

>>> hw/rtl/shcs_core.sv
// Sampling sequencer: walks the seed memory through the hash and drives the result register
`timescale 1ns / 1ps
module shcs_core #(
    parameter int SEED_BYTES = 32,
    parameter int IDX_W      = 5
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  shcs_pkg::cfg_t           cfg,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_func,
    input  logic [4:0]               s_seed_index,
    input  logic [7:0]               s_seed_byte,
    input  logic [2:0]               s_row_i,
    input  logic [2:0]               s_col_j,
    input  logic [9:0]               s_coeff_index,
    input  logic [15:0]              s_poly_index,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [shcs_pkg::Q_W-1:0] m_coefficient,
    output logic                     mem_we,
    output logic [IDX_W-1:0]         mem_waddr,
    output logic [7:0]               mem_wdata,
    output logic                     mem_re,
    output logic [IDX_W-1:0]         mem_raddr,
    input  logic [7:0]               mem_rdata,
    output logic                     div_start,
    output logic [31:0]              div_dividend,
    input  logic                     div_done,
    input  logic [shcs_pkg::Q_W-1:0] div_rem
);
    import shcs_pkg::*;

    localparam int CNT_W = $clog2(SEED_BYTES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CTR1 = 3'd1;
    localparam logic [2:0] S_CTR2 = 3'd2;
    localparam logic [2:0] S_HASH = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic              bin_reg, bin_next;
    logic [2:0]        row_reg, row_next;
    logic [2:0]        col_reg, col_next;
    logic [9:0]        ci_reg, ci_next;
    logic [15:0]       pi_reg, pi_next;
    logic [6:0]        prod_reg, prod_next;
    logic [HASH_W-1:0] ctr_reg, ctr_next;
    logic [HASH_W-1:0] h_reg, h_next;
    logic [CNT_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]  byte_idx_reg, byte_idx_next;
    logic [ETA_W-1:0]  e_reg, e_next;
    logic              half_reg, half_next;
    logic signed [5:0] diff_reg, diff_next;
    logic              neg_reg, neg_next;
    logic              start_reg, start_next;
    logic [31:0]       dvd_reg, dvd_next;
    logic [Q_W-1:0]    res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    logic [Q_W-1:0]    m_coef_reg, m_coef_next;

    logic              accept;
    logic              issue;
    logic [7:0]        cur_byte;
    logic [HASH_W-1:0] h_fin;
    logic signed [5:0] diff_upd;
    logic [5:0]        diff_mag;
    logic              more_e;
    logic [17:0]       ctr_uni;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign issue   = (rd_ptr_reg < CNT_W'(SEED_BYTES));

    always_comb begin
        cur_byte = mem_rdata;
        if (bin_reg && byte_idx_reg == IDX_W'(0)) begin
            cur_byte = mem_rdata ^ pi_reg[7:0];
        end else if (bin_reg && byte_idx_reg == IDX_W'(1)) begin
            cur_byte = mem_rdata ^ pi_reg[15:8];
        end
    end

    assign h_fin    = hash_round(h_reg, cur_byte, ctr_reg);
    assign diff_upd = half_reg ? diff_reg - $signed({5'd0, h_fin[HASH_W-1]})
                               : diff_reg + $signed({5'd0, h_fin[HASH_W-1]});
    assign diff_mag = diff_upd[5] ? 6'(-diff_upd) : 6'(diff_upd);
    assign more_e   = ({1'b0, e_reg} + 6'd1) < {1'b0, cfg.eta_bits};
    assign ctr_uni  = 18'(prod_reg) * 18'(cfg.degree_n) + 18'(ci_reg);

    always_comb begin
        state_next    = state_reg;
        bin_next      = bin_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        ci_next       = ci_reg;
        pi_next       = pi_reg;
        prod_next     = prod_reg;
        ctr_next      = ctr_reg;
        h_next        = h_reg;
        rd_ptr_next   = rd_ptr_reg;
        rd_pend_next  = rd_pend_reg;
        byte_idx_next = byte_idx_reg;
        e_next        = e_reg;
        half_next     = half_reg;
        diff_next     = diff_reg;
        neg_next      = neg_reg;
        start_next    = 1'b0;
        dvd_next      = dvd_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_coef_next   = m_coef_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    bin_next     = (s_func == FUNC_BINOMIAL);
                    row_next     = s_row_i;
                    col_next     = s_col_j;
                    ci_next      = s_coeff_index;
                    pi_next      = s_poly_index;
                    h_next       = HASH_INIT;
                    rd_ptr_next  = '0;
                    rd_pend_next = 1'b0;
                    e_next       = '0;
                    half_next    = 1'b0;
                    diff_next    = '0;
                    ctr_next     = {6'd0, s_coeff_index, 16'd0};
                    if (s_func == FUNC_LOAD) begin
                        mem_we = ({2'b00, s_seed_index} < 7'(SEED_BYTES));
                    end else if (s_func == FUNC_UNIFORM) begin
                        state_next = S_CTR1;
                    end else if (s_func == FUNC_BINOMIAL) begin
                        if (cfg.eta_bits == '0) begin
                            start_next = 1'b1;
                            dvd_next   = '0;
                            neg_next   = 1'b0;
                            state_next = S_DIV;
                        end else begin
                            state_next = S_HASH;
                        end
                    end
                end
            end
            S_CTR1: begin
                prod_next  = 7'(row_reg) * 7'(cfg.rank_k) + 7'(col_reg);
                state_next = S_CTR2;
            end
            S_CTR2: begin
                ctr_next   = 32'(ctr_uni);
                state_next = S_HASH;
            end
            S_HASH: begin
                mem_re       = issue;
                rd_pend_next = issue;
                if (issue) begin
                    rd_ptr_next   = rd_ptr_reg + CNT_W'(1);
                    byte_idx_next = rd_ptr_reg[IDX_W-1:0];
                end
                if (rd_pend_reg) begin
                    h_next = h_fin;
                end
                if (rd_pend_reg && !issue) begin
                    if (!bin_reg) begin
                        start_next = 1'b1;
                        dvd_next   = h_fin;
                        neg_next   = 1'b0;
                        state_next = S_DIV;
                    end else begin
                        diff_next = diff_upd;
                        if (more_e || !half_reg) begin
                            e_next       = more_e ? e_reg + ETA_W'(1) : '0;
                            half_next    = more_e ? half_reg : 1'b1;
                            h_next       = HASH_INIT;
                            rd_ptr_next  = '0;
                            rd_pend_next = 1'b0;
                            ctr_next     = {6'd0, ci_reg, 3'd0,
                                            (more_e ? e_reg + ETA_W'(1) : ETA_W'(0)),
                                            7'd0, (more_e ? half_reg : 1'b1)};
                        end else begin
                            start_next = 1'b1;
                            dvd_next   = 32'(diff_mag);
                            neg_next   = diff_upd[5];
                            state_next = S_DIV;
                        end
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (cfg.modulus_q == '0) begin
                        res_next = '0;
                    end else if (neg_reg && div_rem != '0) begin
                        res_next = cfg.modulus_q - div_rem;
                    end else begin
                        res_next = div_rem;
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_coef_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            rd_pend_reg <= 1'b0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_pend_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg      <= bin_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        ci_reg       <= ci_next;
        pi_reg       <= pi_next;
        prod_reg     <= prod_next;
        ctr_reg      <= ctr_next;
        h_reg        <= h_next;
        rd_ptr_reg   <= rd_ptr_next;
        byte_idx_reg <= byte_idx_next;
        e_reg        <= e_next;
        half_reg     <= half_next;
        diff_reg     <= diff_next;
        neg_reg      <= neg_next;
        dvd_reg      <= dvd_next;
        res_reg      <= res_next;
        m_coef_reg   <= m_coef_next;
    end

    assign mem_waddr     = IDX_W'(s_seed_index);
    assign mem_wdata     = s_seed_byte;
    assign mem_raddr     = rd_ptr_reg[IDX_W-1:0];
    assign div_start     = start_reg;
    assign div_dividend  = dvd_reg;
    assign m_valid       = m_valid_reg;
    assign m_coefficient = m_coef_reg;
endmodule

>>> hw/rtl/seeded_hash_coefficient_sampler.sv
// Top level: APB register file, seed memory, sampling sequencer and remainder unit
//
// Seed bytes are loaded one per transfer. A uniform sample passes from its transfer
// through S_CTR1 and S_CTR2, which form the counter, then S_HASH, with one seed
// memory read per byte in each hash pass, then S_DIV, where the bit-serial remainder
// unit starts, develops the quotient bits and signals done, then S_OUT, which loads the
// output register, and back to idle. A binomial sample runs 2 * eta_bits hash passes
// over the seed memory. The seed memory read port sets the pace of each hash pass.
// One sample is in flight at a time; a finished result waits in the output register
// while the next transfer is taken.
`timescale 1ns / 1ps
`include "seeded_hash_coefficient_sampler_macros.svh"
module seeded_hash_coefficient_sampler #(
    parameter int SEED_BYTES = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [shcs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [shcs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [shcs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_func,
    input  logic [4:0]                       s_seed_index,
    input  logic [7:0]                       s_seed_byte,
    input  logic [2:0]                       s_row_i,
    input  logic [2:0]                       s_col_j,
    input  logic [9:0]                       s_coeff_index,
    input  logic [15:0]                      s_poly_index,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [shcs_pkg::Q_W-1:0]         m_coefficient
);
    import shcs_pkg::*;

    localparam int IDX_W = (SEED_BYTES > 1) ? $clog2(SEED_BYTES) : 1;

    logic [Q_W-1:0]    modulus_q_reg, modulus_q_next;
    logic [RANK_W-1:0] rank_k_reg, rank_k_next;
    logic [DEG_W-1:0]  degree_n_reg, degree_n_next;
    logic [ETA_W-1:0]  eta_bits_reg, eta_bits_next;
    logic              cfg_wr;
    logic [1:0]        reg_sel;
    cfg_t              cfg;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    logic [7:0]        mem_rdata;
    logic              div_start;
    logic [31:0]       div_dividend;
    logic              div_done;
    logic [Q_W-1:0]    div_rem;

    logic              coef_in_range;
    logic              sample_xfer;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[3:2];

    always_comb begin
        modulus_q_next = modulus_q_reg;
        rank_k_next    = rank_k_reg;
        degree_n_next  = degree_n_reg;
        eta_bits_next  = eta_bits_reg;
        if (cfg_wr) begin
            unique case (reg_sel)
                REG_MODULUS: modulus_q_next = pwdata[Q_W-1:0];
                REG_RANK:    rank_k_next    = pwdata[RANK_W-1:0];
                REG_DEGREE:  degree_n_next  = pwdata[DEG_W-1:0];
                REG_ETA:     eta_bits_next  = pwdata[ETA_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_MODULUS: prdata = APB_DATA_W'(modulus_q_reg);
            REG_RANK:    prdata = APB_DATA_W'(rank_k_reg);
            REG_DEGREE:  prdata = APB_DATA_W'(degree_n_reg);
            REG_ETA:     prdata = APB_DATA_W'(eta_bits_reg);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_q_reg <= MODULUS_RST;
            rank_k_reg    <= RANK_RST;
            degree_n_reg  <= DEGREE_RST;
            eta_bits_reg  <= ETA_RST;
        end else begin
            modulus_q_reg <= modulus_q_next;
            rank_k_reg    <= rank_k_next;
            degree_n_reg  <= degree_n_next;
            eta_bits_reg  <= eta_bits_next;
        end
    end

    assign cfg.modulus_q = modulus_q_reg;
    assign cfg.rank_k    = rank_k_reg;
    assign cfg.degree_n  = degree_n_reg;
    assign cfg.eta_bits  = eta_bits_reg;

    shcs_seed_mem #(
        .SEED_BYTES (SEED_BYTES),
        .IDX_W      (IDX_W)
    ) u_seed_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    shcs_rem_unit u_rem_unit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (modulus_q_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    shcs_core #(
        .SEED_BYTES (SEED_BYTES),
        .IDX_W      (IDX_W)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_seed_index  (s_seed_index),
        .s_seed_byte   (s_seed_byte),
        .s_row_i       (s_row_i),
        .s_col_j       (s_col_j),
        .s_coeff_index (s_coeff_index),
        .s_poly_index  (s_poly_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_coefficient (m_coefficient),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_re        (mem_re),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata),
        .div_start     (div_start),
        .div_dividend  (div_dividend),
        .div_done      (div_done),
        .div_rem       (div_rem)
    );

    assign coef_in_range = (m_coefficient < modulus_q_reg) ||
                           ((modulus_q_reg == '0) && (m_coefficient == '0));
    assign sample_xfer   = s_valid && s_ready &&
                           ((s_func == FUNC_UNIFORM) || (s_func == FUNC_BINOMIAL));

    // result always reduced below q, or zero when q is zero
    `SHCS_ASSERT_SAME(a_coef_range, aclk, aresetn, m_valid, coef_in_range)
    // a sample transfer makes the block busy on the next cycle
    `SHCS_ASSERT_NEXT(a_busy_after_sample, aclk, aresetn, sample_xfer, !s_ready)
    // seed memory is never written and read in the same cycle
    `SHCS_ASSERT_SAME(a_mem_port_excl, aclk, aresetn, mem_we, !mem_re)
endmodule
